// ===== rtl/core/fsps_pkg.sv =====
// Shared types and constants for the fill-run free space scanner.
// Used by every module in rtl/core; has no dependencies of its own.
package fsps_pkg;

   localparam int ADDR_BITS_DEF     = 24;
   localparam int MIN_RUN_BYTES_DEF = 32;

   localparam int DATA_W      = 8;
   localparam int RANGE_W     = 24;
   localparam int COUNT_W     = 25;
   localparam int OFF_W       = 4;
   localparam int BLOCK_BYTES = 16;
   localparam int PAT_W       = 12;

   localparam logic [PAT_W-1:0] END_PAT_HDR   = 12'h1FF;
   localparam logic [PAT_W-1:0] END_PAT_PLAIN = 12'hFFF;

   localparam logic [COUNT_W-1:0] TOTAL_MAX = '1;

   localparam logic KIND_RANGE = 1'b0;
   localparam logic KIND_TOTAL = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_BYTE      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_PRESENT = 1'b1;

   // range_start, range_end and byte_count packed, padded to whole bytes.
   localparam int RSP_FIELDS_W = 2 * RANGE_W + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic               kind;
      logic [RANGE_W-1:0] range_start;
      logic [RANGE_W-1:0] range_end;
      logic [COUNT_W-1:0] byte_count;
      logic               is_last;
   } rsp_item_type;

   // Up to two results produced by one byte, compacted into item0 first.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

endpackage

// ===== rtl/core/fsps_scan.sv =====
// Input register and per-byte scan logic: block tracking, run closing and totals.
// Depends on fsps_pkg; feeds fsps_rsp_fifo with up to two results per byte.
module fsps_scan #(
   parameter int ADDR_BITS     = fsps_pkg::ADDR_BITS_DEF,
   parameter int MIN_RUN_BYTES = fsps_pkg::MIN_RUN_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [fsps_pkg::DATA_W-1:0] in_data,
   input  logic                        in_last,
   input  logic                        room,
   input  logic [fsps_pkg::DATA_W-1:0] fill_byte,
   input  logic                        header_present,
   output fsps_pkg::rsp_push_type      push
);

   localparam int BA_W       = ADDR_BITS + 1;
   localparam int SAT_BLOCKS = (MIN_RUN_BYTES + 15) / 16;
   localparam int CNT_W      = $clog2(SAT_BLOCKS + 1);
   localparam int FL_W       = $clog2(SAT_BLOCKS * 16 + 16);
   localparam int TW         = ((BA_W > fsps_pkg::COUNT_W) ? BA_W : fsps_pkg::COUNT_W) + 1;
   localparam int OW         = fsps_pkg::OFF_W;

   logic                         vld_ff;
   logic [fsps_pkg::DATA_W-1:0]  data_ff;
   logic                         last_ff;

   logic [BA_W-1:0]              ba_ff, ba_in;
   logic                         baf_ff, baf_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0]         start_ff, start_in;
   logic [fsps_pkg::COUNT_W-1:0] total_ff, total_in;

   logic                         go;
   logic                         in_space, fill, close_early, block_done, baf_mid;
   logic [OW-1:0]                off;
   logic [BA_W-1:0]              base, ba_next, bound_late, bound_sel, end_sel, run_len;
   logic [CNT_W-1:0]             cnt_mid, cnt_sel;
   logic [ADDR_BITS-1:0]         start_sel;
   logic [FL_W-1:0]              flen_early, flen_late, flen_sel;
   logic [fsps_pkg::PAT_W-1:0]   pat;
   logic                         emit;
   logic [TW-1:0]                sum;
   logic [fsps_pkg::COUNT_W-1:0] total_new;
   fsps_pkg::rsp_item_type       range_item, total_item;

   assign go       = vld_ff && room;
   assign in_ready = !vld_ff || room;

   always_comb begin
      in_space    = !ba_ff[ADDR_BITS];
      fill        = in_space && (data_ff == fill_byte);
      off         = ba_ff[OW-1:0];
      base        = {ba_ff[BA_W-1:OW], {OW{1'b0}}};
      close_early = baf_ff && !fill;
      baf_mid     = baf_ff && fill;
      cnt_mid     = close_early ? '0 : cnt_ff;
      block_done  = in_space && (off == {OW{1'b1}});

      // A fully matching block extends the run; the first one marks its start.
      start_in = start_ff;
      cnt_in   = cnt_mid;
      if (block_done && baf_mid) begin
         if (cnt_mid == '0) begin
            start_in = base[ADDR_BITS-1:0];
         end
         if (cnt_mid < CNT_W'(SAT_BLOCKS)) begin
            cnt_in = cnt_mid + 1'b1;
         end
      end
      baf_in  = block_done ? 1'b1 : baf_mid;
      ba_next = in_space ? ba_ff + 1'b1 : ba_ff;

      flen_early = FL_W'({cnt_ff, {OW{1'b0}}}) + FL_W'(off);
      bound_late = {ba_next[BA_W-1:OW], {OW{1'b0}}};
      flen_late  = FL_W'({cnt_in, {OW{1'b0}}})
                 + (baf_in ? FL_W'(ba_next[OW-1:0]) : '0);

      // At most one run closes per byte: a closing non-fill byte leaves no run
      // open for the end-of-image close.
      cnt_sel   = close_early ? cnt_ff     : cnt_in;
      start_sel = close_early ? start_ff   : start_in;
      bound_sel = close_early ? base       : bound_late;
      flen_sel  = close_early ? flen_early : flen_late;

      end_sel = bound_sel - 1'b1;
      run_len = bound_sel - BA_W'(start_sel);
      pat     = header_present ? fsps_pkg::END_PAT_HDR : fsps_pkg::END_PAT_PLAIN;

      emit = (close_early || last_ff)
          && (cnt_sel != '0)
          && (bound_sel[BA_W-1:OW] != '0)
          && (flen_sel >= FL_W'(MIN_RUN_BYTES))
          && (end_sel[fsps_pkg::PAT_W-1:0] == pat)
          && (bound_sel > BA_W'(start_sel));

      sum = TW'(total_ff) + TW'(run_len);
      if (!emit) begin
         total_new = total_ff;
      end else if (sum > TW'(fsps_pkg::TOTAL_MAX)) begin
         total_new = fsps_pkg::TOTAL_MAX;
      end else begin
         total_new = sum[fsps_pkg::COUNT_W-1:0];
      end
      total_in = total_new;

      range_item.kind        = fsps_pkg::KIND_RANGE;
      range_item.range_start = fsps_pkg::RANGE_W'(start_sel);
      range_item.range_end   = fsps_pkg::RANGE_W'(end_sel);
      range_item.byte_count  = fsps_pkg::COUNT_W'(run_len);
      range_item.is_last     = 1'b0;

      total_item.kind        = fsps_pkg::KIND_TOTAL;
      total_item.range_start = '0;
      total_item.range_end   = '0;
      total_item.byte_count  = total_new;
      total_item.is_last     = 1'b1;

      push.count = go ? (2'(emit) + 2'(last_ff)) : 2'd0;
      push.item0 = emit ? range_item : total_item;
      push.item1 = total_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= 1'b0;
         ba_ff    <= '0;
         baf_ff   <= 1'b1;
         cnt_ff   <= '0;
         start_ff <= '0;
         total_ff <= '0;
      end else begin
         if (in_ready) begin
            vld_ff <= in_valid;
         end
         if (go) begin
            if (last_ff) begin
               // The image is done; the next byte starts a new one at address zero.
               ba_ff    <= '0;
               baf_ff   <= 1'b1;
               cnt_ff   <= '0;
               start_ff <= '0;
               total_ff <= '0;
            end else begin
               ba_ff    <= ba_next;
               baf_ff   <= baf_in;
               cnt_ff   <= cnt_in;
               start_ff <= start_in;
               total_ff <= total_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
         last_ff <= in_last;
      end
   end

endmodule

// ===== rtl/core/fsps_rsp_fifo.sv =====
// Result queue: takes up to two results a cycle from the scan logic, hands out one.
// Depends on fsps_pkg for the result types and the queue depth.
module fsps_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  fsps_pkg::rsp_push_type push,
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output fsps_pkg::rsp_item_type out_item
);

   localparam int PTR_W = $clog2(fsps_pkg::RSP_DEPTH);

   fsps_pkg::rsp_item_type entry_ff [fsps_pkg::RSP_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;
   logic                   pop;
   logic [PTR_W-1:0]       wr_ptr_next;

   // Room is judged on the stored count alone, so two free slots are needed.
   assign room      = count_ff <= (PTR_W+1)'(fsps_pkg::RSP_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_next = wr_ptr_ff + 1'b1;
      wr_ptr_in   = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(pop);
      count_in    = count_ff + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.item1;
      end
   end

endmodule

// ===== rtl/core/fill_run_free_space_scanner_unit.sv =====
// Top level of the fill-run free space scanner: stream ports and configuration registers.
// Depends on fsps_pkg, fsps_scan and fsps_rsp_fifo.
//
// The scanner takes one image byte per beat and accepts a new beat every cycle. A byte
// passes an input register and is judged against the fill byte; its results are
// registered into a four-entry result queue, from which they are offered. A byte
// yields at most two results (a range report and the final total), and the result port
// hands out one per cycle, so the sustained rate is one byte per cycle as long as
// results are taken as fast as they appear; when the queue holds more than two results,
// the input stalls until it drains.
module fill_run_free_space_scanner_unit #(
   parameter int ADDR_BITS     = fsps_pkg::ADDR_BITS_DEF,
   parameter int MIN_RUN_BYTES = fsps_pkg::MIN_RUN_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fsps_pkg::DATA_W-1:0]          req_tdata,  // [7:0] data_byte
   input  logic                                 req_tlast,  // end_of_image
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [23:0] range_start, [47:24] range_end, [72:48] byte_count, rest zero
   output logic [fsps_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tuser,  // kind
   output logic                                 rsp_tlast,  // is_last
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fsps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fsps_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic [fsps_pkg::DATA_W-1:0] fill_byte_ff;
   logic                        header_present_ff;
   logic                        room;
   fsps_pkg::rsp_push_type      push;
   fsps_pkg::rsp_item_type      out_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_byte_ff      <= '0;
         header_present_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fsps_pkg::CSR_FILL_BYTE: begin
               fill_byte_ff <= csr_data[fsps_pkg::DATA_W-1:0];
            end
            fsps_pkg::CSR_HEADER_PRESENT: begin
               header_present_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   fsps_scan #(
      .ADDR_BITS     (ADDR_BITS),
      .MIN_RUN_BYTES (MIN_RUN_BYTES)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_data        (req_tdata),
      .in_last        (req_tlast),
      .room           (room),
      .fill_byte      (fill_byte_ff),
      .header_present (header_present_ff),
      .push           (push)
   );

   fsps_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {{(fsps_pkg::RSP_TDATA_W - fsps_pkg::RSP_FIELDS_W){1'b0}},
                       out_item.byte_count, out_item.range_end, out_item.range_start};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.is_last;

endmodule

// ===== rtl/core/fsps_checker.sv =====
// Port-level checks for the fill-run free space scanner, bound to the top level.
// Depends on fsps_pkg and fill_run_free_space_scanner_unit.
module fsps_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [fsps_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   // A result beat waiting on the consumer holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Only the total report closes the stream.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == fsps_pkg::KIND_TOTAL) == rsp_tlast)
      else $error("last flag does not match the total report");

   // A reported range starts on a block boundary and ends on a block's last byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == fsps_pkg::KIND_RANGE
      |-> rsp_tdata[3:0] == 4'h0 && rsp_tdata[27:24] == 4'hF)
      else $error("range is not block aligned");

   // The total report carries no addresses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == fsps_pkg::KIND_TOTAL |-> rsp_tdata[47:0] == '0)
      else $error("total report carries addresses");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind fill_run_free_space_scanner_unit fsps_checker u_fsps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== verif/tb_fill_run_free_space_scanner_unit.sv =====
// Self-checking testbench for fill_run_free_space_scanner_unit: image byte streams in,
// free range and total reports out, checked against an in-bench scanner model.
// Depends on fsps_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_fill_run_free_space_scanner_unit;

   localparam int ADDR_BITS     = fsps_pkg::ADDR_BITS_DEF;
   localparam int MIN_RUN       = fsps_pkg::MIN_RUN_BYTES_DEF;
   localparam int SAT_BLOCKS    = (MIN_RUN + 15) / 16;
   localparam int SETTLE_CYCLES = 8;
   localparam int DATA_W        = fsps_pkg::DATA_W;
   localparam int RANGE_W       = fsps_pkg::RANGE_W;
   localparam int COUNT_W       = fsps_pkg::COUNT_W;
   localparam int PAT_W         = fsps_pkg::PAT_W;
   localparam int RSP_TDATA_W   = fsps_pkg::RSP_TDATA_W;
   localparam int CSR_INDEX_W   = fsps_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W    = fsps_pkg::CSR_DATA_W;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata = '0;  // [7:0] data_byte
   logic                   req_tlast = 1'b0;  // end_of_image
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [23:0] range_start, [47:24] range_end, [72:48] byte_count, rest zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;  // kind
   logic                   rsp_tlast;  // is_last
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   fill_run_free_space_scanner_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Scanner model state and register copies.
   logic [DATA_W-1:0]    fill_value;
   logic                 hdr_mode;
   logic [ADDR_BITS:0]   scan_addr;
   logic                 blk_fill;
   logic [1:0]           run_blocks;
   logic [RANGE_W-1:0]   run_base;
   logic [COUNT_W-1:0]   free_total;

   fsps_pkg::rsp_item_type expected_rsp[$];
   int                     error_count = 0;
   int                     send_idle_pct = 12;
   int                     recv_idle_pct = 65;

   task automatic clear_scan_state();
      scan_addr  = '0;
      blk_fill   = 1'b1;
      run_blocks = '0;
      run_base   = '0;
      free_total = '0;
   endtask

   // Closes the current run at a block boundary and queues a range report when it
   // is long enough and ends on the selected address pattern.
   task automatic close_free_run(input logic [ADDR_BITS:0] boundary,
                                 input int unsigned fill_len);
      logic [ADDR_BITS:0]     last_addr;
      logic [ADDR_BITS:0]     run_len;
      logic [PAT_W-1:0]       pat;
      logic [COUNT_W:0]       total_sum;
      fsps_pkg::rsp_item_type item;
      pat = hdr_mode ? fsps_pkg::END_PAT_HDR : fsps_pkg::END_PAT_PLAIN;
      if (run_blocks > 0 && boundary >= 16 && fill_len >= MIN_RUN) begin
         last_addr = boundary - 1'b1;
         if (last_addr[PAT_W-1:0] == pat && last_addr >= {1'b0, run_base}) begin
            run_len = last_addr - {1'b0, run_base} + 1'b1;
            item.kind        = fsps_pkg::KIND_RANGE;
            item.range_start = run_base;
            item.range_end   = last_addr[RANGE_W-1:0];
            item.byte_count  = run_len;
            item.is_last     = 1'b0;
            expected_rsp.push_back(item);
            total_sum  = {1'b0, free_total} + {1'b0, run_len};
            free_total = (total_sum > {1'b0, fsps_pkg::TOTAL_MAX}) ? fsps_pkg::TOTAL_MAX
                                                                   : total_sum[COUNT_W-1:0];
         end
      end
      run_blocks = '0;
   endtask

   task automatic predict_byte(input logic [DATA_W-1:0] data_byte, input logic eoi);
      logic                   in_range;
      logic                   is_fill;
      logic [3:0]             off;
      logic [ADDR_BITS:0]     base;
      logic [ADDR_BITS:0]     boundary;
      int unsigned            len;
      fsps_pkg::rsp_item_type item;
      // The address saturates at the top of the address space; such bytes are non-fill.
      in_range = !scan_addr[ADDR_BITS];
      is_fill  = in_range && (data_byte == fill_value);
      off      = scan_addr[3:0];
      base     = {scan_addr[ADDR_BITS:4], 4'b0};
      if (blk_fill && !is_fill) begin
         close_free_run(base, run_blocks * 16 + off);
         blk_fill = 1'b0;
      end
      if (in_range && off == 4'hF) begin
         if (blk_fill) begin
            if (run_blocks == 0)
               run_base = base[RANGE_W-1:0];
            if (run_blocks < SAT_BLOCKS)
               run_blocks++;
         end
         blk_fill = 1'b1;
      end
      if (in_range)
         scan_addr++;
      if (eoi) begin
         // A partial final block never joins a range but its fill bytes count toward length.
         boundary = {scan_addr[ADDR_BITS:4], 4'b0};
         len = run_blocks * 16;
         if (blk_fill)
            len += scan_addr[3:0];
         close_free_run(boundary, len);
         item.kind        = fsps_pkg::KIND_TOTAL;
         item.range_start = '0;
         item.range_end   = '0;
         item.byte_count  = free_total;
         item.is_last     = 1'b1;
         expected_rsp.push_back(item);
         clear_scan_state();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch on %s: got %0h, expected %0h", what, got, want);
   endtask

   fsps_pkg::rsp_item_type rsp_want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result",
                            32'(rsp_tdata[2*RANGE_W+COUNT_W-1:2*RANGE_W]), 32'd0);
         end else begin
            rsp_want = expected_rsp.pop_front();
            if (rsp_tuser !== rsp_want.kind)
               report_mismatch("kind", 32'(rsp_tuser), 32'(rsp_want.kind));
            if (rsp_tdata[RANGE_W-1:0] !== rsp_want.range_start)
               report_mismatch("range_start", 32'(rsp_tdata[RANGE_W-1:0]),
                               32'(rsp_want.range_start));
            if (rsp_tdata[2*RANGE_W-1:RANGE_W] !== rsp_want.range_end)
               report_mismatch("range_end", 32'(rsp_tdata[2*RANGE_W-1:RANGE_W]),
                               32'(rsp_want.range_end));
            if (rsp_tdata[2*RANGE_W+COUNT_W-1:2*RANGE_W] !== rsp_want.byte_count)
               report_mismatch("byte_count", 32'(rsp_tdata[2*RANGE_W+COUNT_W-1:2*RANGE_W]),
                               32'(rsp_want.byte_count));
            if (rsp_tlast !== rsp_want.is_last)
               report_mismatch("is_last", 32'(rsp_tlast), 32'(rsp_want.is_last));
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // Called at a falling edge; returns at a falling edge with tvalid still high.
   task automatic send_byte(input logic [DATA_W-1:0] data_byte, input logic eoi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tlast  <= eoi;
      do
         @(posedge clock);
      while (!req_tready);
      predict_byte(data_byte, eoi);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      if (index == fsps_pkg::CSR_FILL_BYTE)
         fill_value = value;
      else
         hdr_mode = value[0];
      @(negedge clock);
   endtask

   // Only bit 0 of the header register matters; the upper bits carry junk on purpose.
   task automatic configure(input logic [DATA_W-1:0] fill, input logic hdr);
      logic [6:0] junk;
      junk = 7'($urandom_range(0, 127));
      write_csr(fsps_pkg::CSR_FILL_BYTE, fill);
      write_csr(fsps_pkg::CSR_HEADER_PRESENT, {junk, hdr});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_fill();
      case ($urandom_range(0, 3))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] noise_byte();
      if ($urandom_range(0, 3) == 0)
         return fill_value;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_short_image(input int len);
      logic [DATA_W-1:0] b;
      for (int a = 0; a < len; a++) begin
         b = ($urandom_range(0, 1) == 0) ? fill_value : 8'($urandom_range(0, 255));
         send_byte(b, a == len - 1);
      end
   endtask

   // Image with a fill run whose whole blocks end just before the given boundary. The run spans
   // 'blocks' whole blocks plus 'lead' bytes in front and 'over' bytes behind, and a
   // non-fill byte follows it. The rest is noise, with an occasional all-fill block.
   task automatic send_long_image(input int boundary, input int blocks, input int lead,
                                  input int over, input int img_len, input int pause_at);
      int                run_lo;
      int                run_hi;
      logic              noise_blk;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] flip;
      run_lo    = boundary - 16 * blocks - lead;
      run_hi    = boundary - 1 + over;
      noise_blk = 1'b0;
      for (int a = 0; a < img_len; a++) begin
         if (a % 16 == 0)
            noise_blk = ($urandom_range(0, 9) == 0);
         if (a >= run_lo && a <= run_hi) begin
            b = fill_value;
         end else if (a == run_hi + 1) begin
            flip = 8'($urandom_range(1, 255));
            b = fill_value ^ flip;
         end else if (noise_blk) begin
            b = fill_value;
         end else begin
            b = noise_byte();
         end
         if (a == pause_at)
            wait_for_results();
         send_byte(b, a == img_len - 1);
      end
   endtask

   // Short images straight after reset, with the reset register values.
   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      for (int a = 0; a < 20; a++)
         send_byte(8'h00, a == 19);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b1);
      wait_for_results();
   endtask

   task automatic test_end_patterns();
      configure(8'h00, 1'b1);
      // A run ending on the header pattern is closed by a non-fill byte; the sender
      // holds off mid-image until every result is in.
      send_long_image(32'h200, 2, 5, 7, 32'h210, 32'h1F0);
      wait_for_results();
   endtask

   task automatic test_random_images(input int budget);
      int   sent;
      int   img;
      int   len;
      logic hdr;
      sent = 0;
      img  = 0;
      while (sent < budget) begin
         if (img % 4 == 0) begin
            wait_for_results();
            hdr = ($urandom_range(0, 99) < 50);
            configure(pick_fill(), hdr);
         end
         len = $urandom_range(1, 32);
         send_short_image(len);
         sent += len;
         img++;
      end
      wait_for_results();
   endtask

   initial begin
      fill_value = '0;
      hdr_mode   = 1'b0;
      clear_scan_state();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_end_patterns();

      send_idle_pct = 12;
      recv_idle_pct = 65;
      test_random_images(95);
      send_idle_pct = 65;
      recv_idle_pct = 12;
      test_random_images(95);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_images(95);

      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
